FILE: rtl/rdm_packet_framer_unit_assert.svh
// assertion macros for the rdm packet framer
`ifndef RDM_PACKET_FRAMER_UNIT_ASSERT_SVH
`define RDM_PACKET_FRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define RDM_PF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define RDM_PF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RDM_PF_ASSERT(lbl, clk, rstn, prop, msg)
`define RDM_PF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/rdm_pf_pkg.sv
`default_nettype none

package rdm_pf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned UID_W     = 48;
  localparam int unsigned MID_W     = 40;
  localparam int unsigned PID_W     = 16;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 48;

  localparam logic [BYTE_W-1:0] HDR_BYTES = 8'd24;

  // item modes
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_DATA   = 1'b1;

  // sequencer steps: 0..23 header bytes (0 also for a data byte), then the two checksum bytes
  localparam logic [STEP_W-1:0] STEP_FIRST  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_HDR_LAST = 5'd23;
  localparam logic [STEP_W-1:0] STEP_CKS_HI = 5'd24;
  localparam logic [STEP_W-1:0] STEP_CKS_LO = 5'd25;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_START_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_UID        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_FIELDS  = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] sub_start_code;
    logic [UID_W-1:0]  src_uid;
    logic [MID_W-1:0]  middle_fields;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } emit_t;

  typedef struct packed {
    logic              in_packet;
    logic [STEP_W-1:0] step;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/rdm_packet_framer_unit.sv
`default_nettype none

// rdm message framer. a header transfer (mode 0) opens a message and produces its
// 24 header bytes: start code, sub-start code, message length (24 + data length),
// destination uid, source uid, five middle bytes, command class, parameter id and
// data length. each data transfer (mode 1) that follows produces one byte, and after
// the last one the 16-bit wrapping sum of all bytes goes out high byte first, the low
// byte flagged with out_last. zero data length closes the message right after the
// header. a new header abandons an open message without a checksum, and data
// transfers that arrive when no byte is expected are taken and dropped. the block
// puts out one byte per cycle, while out_stall is low, through a single output
// register: a transfer holds the input until its final byte, checksum included, is
// taken, a dropped data transfer is let go at once, and the next transfer is taken
// in the cycle the current one produces its final byte. the configuration
// registers are read while the header goes out; the user must write them only
// while the block is idle (not enforced by the block); cfg_ready is always high.
module rdm_packet_framer_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration write channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [rdm_pf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [rdm_pf_pkg::CFG_DAT_W-1:0]      cfg_data,
  // input items
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_mode,
  input  wire [rdm_pf_pkg::UID_W-1:0]          in_dest_uid,
  input  wire [rdm_pf_pkg::BYTE_W-1:0]         in_command_class,
  input  wire [rdm_pf_pkg::PID_W-1:0]          in_parameter_id,
  input  wire [rdm_pf_pkg::BYTE_W-1:0]         in_data_length,
  input  wire [rdm_pf_pkg::BYTE_W-1:0]         in_data_byte,
  // message bytes
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [rdm_pf_pkg::BYTE_W-1:0]        out_byte,
  output logic                                 out_last
);
  import rdm_pf_pkg::*;

  `include "rdm_packet_framer_unit_assert.svh"

  cfg_t              cfg_r;
  emit_t             emit;
  status_t           status;
  logic              emit_ready;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  // checksum byte offered this cycle
  logic              cks_emit;
  logic              last_fire;

  // configuration registers, one write per transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code     <= 8'hCC;
      cfg_r.sub_start_code <= 8'h01;
      cfg_r.src_uid        <= '0;
      cfg_r.middle_fields  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_CODE:     cfg_r.start_code     <= cfg_data[BYTE_W-1:0];
        CFG_SUB_START_CODE: cfg_r.sub_start_code <= cfg_data[BYTE_W-1:0];
        CFG_SRC_UID:        cfg_r.src_uid        <= cfg_data[UID_W-1:0];
        CFG_MIDDLE_FIELDS:  cfg_r.middle_fields  <= cfg_data[MID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // item register, message state and byte sequencer
  rdm_pf_emitter u_emitter (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_dest_uid      (in_dest_uid),
    .in_command_class (in_command_class),
    .in_parameter_id  (in_parameter_id),
    .in_data_length   (in_data_length),
    .in_data_byte     (in_data_byte),
    .emit_ready       (emit_ready),
    .emit             (emit),
    .status           (status)
  );

  // output register: refills whenever empty or being drained this cycle
  assign emit_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit.valid) begin
      out_byte_r <= emit.data;
      out_last_r <= emit.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  assign cks_emit  = emit.valid &&
                     (status.step == STEP_CKS_HI || status.step == STEP_CKS_LO);
  assign last_fire = emit.valid && emit_ready && emit.last;

  // checksum bytes only go out inside an open message
  `RDM_PF_ASSERT(a_cks_in_packet, clk, rst_n, cks_emit |-> status.in_packet, "cks outside msg")

  // the low checksum byte closes the message
  `RDM_PF_ASSERT(a_last_closes, clk, rst_n, last_fire |=> !status.in_packet, "msg open at end")

  // nothing leaves the block right after reset
  `RDM_PF_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

`default_nettype wire

FILE: rtl/rdm_pf_emitter.sv
`default_nettype none

module rdm_pf_emitter (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire rdm_pf_pkg::cfg_t                cfg,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_mode,
  input  wire [rdm_pf_pkg::UID_W-1:0]          in_dest_uid,
  input  wire [rdm_pf_pkg::BYTE_W-1:0]         in_command_class,
  input  wire [rdm_pf_pkg::PID_W-1:0]          in_parameter_id,
  input  wire [rdm_pf_pkg::BYTE_W-1:0]         in_data_length,
  input  wire [rdm_pf_pkg::BYTE_W-1:0]         in_data_byte,
  input  wire                                  emit_ready,
  output rdm_pf_pkg::emit_t                    emit,
  output rdm_pf_pkg::status_t                  status
);
  import rdm_pf_pkg::*;

  // held item
  logic              item_vld_r;
  logic              mode_r;
  logic [UID_W-1:0]  dest_r;
  logic [BYTE_W-1:0] cls_r;
  logic [PID_W-1:0]  pid_r;
  logic [BYTE_W-1:0] len_r;
  logic [BYTE_W-1:0] dbyte_r;

  // message state
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [BYTE_W-1:0] rem_r;
  logic              inpkt_r;

  logic              is_hdr;
  logic              ignore;
  logic              fire;
  logic              final_step;
  logic              item_done;
  logic              in_acc;
  logic [191:0]      hdr_vec;
  logic [STEP_W-1:0] hdr_sel;
  logic [BYTE_W-1:0] hdr_byte;
  logic [BYTE_W-1:0] byte_sel;

  assign is_hdr = (mode_r == MODE_HEADER);
  // data item with nothing expected: dropped without a byte
  assign ignore = item_vld_r && !is_hdr && (step_r == STEP_FIRST) &&
                  (!inpkt_r || rem_r == '0);

  assign hdr_vec = {cfg.start_code, cfg.sub_start_code, HDR_BYTES + len_r, dest_r,
                    cfg.src_uid, cfg.middle_fields, cls_r, pid_r, len_r};
  assign hdr_sel = (step_r <= STEP_HDR_LAST) ? (STEP_HDR_LAST - step_r) : '0;
  assign hdr_byte = hdr_vec[{hdr_sel, 3'b000} +: BYTE_W];

  always_comb begin
    emit.valid = item_vld_r && !ignore;
    emit.last  = 1'b0;
    if (step_r == STEP_CKS_HI) begin
      byte_sel = sum_r[SUM_W-1:BYTE_W];
    end else if (step_r == STEP_CKS_LO) begin
      byte_sel  = sum_r[BYTE_W-1:0];
      emit.last = 1'b1;
    end else if (is_hdr) begin
      byte_sel = hdr_byte;
    end else begin
      byte_sel = dbyte_r;
    end
    emit.data = byte_sel;
  end

  assign fire = emit.valid && emit_ready;

  always_comb begin
    if (step_r == STEP_CKS_LO) begin
      final_step = 1'b1;
    end else if (step_r == STEP_CKS_HI) begin
      final_step = 1'b0;
    end else if (is_hdr) begin
      final_step = (step_r == STEP_HDR_LAST) && (len_r != '0);
    end else begin
      final_step = (rem_r != 8'd1);
    end
  end

  always_comb begin
    if (step_r == STEP_CKS_HI) begin
      step_nxt = STEP_CKS_LO;
    end else if (is_hdr && step_r != STEP_HDR_LAST) begin
      step_nxt = step_r + 5'd1;
    end else begin
      step_nxt = STEP_CKS_HI;
    end
  end

  assign item_done = ignore || (fire && final_step);
  assign in_stall  = item_vld_r && !item_done;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      step_r     <= STEP_FIRST;
      sum_r      <= '0;
      rem_r      <= '0;
      inpkt_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        item_vld_r <= 1'b1;
      end else if (item_done) begin
        item_vld_r <= 1'b0;
      end

      if (item_done) begin
        step_r <= STEP_FIRST;
      end else if (fire) begin
        step_r <= step_nxt;
      end

      if (fire) begin
        if (step_r == STEP_CKS_LO) begin
          sum_r   <= '0;
          rem_r   <= '0;
          inpkt_r <= 1'b0;
        end else if (step_r == STEP_CKS_HI) begin
          sum_r <= sum_r;
        end else if (is_hdr && step_r == STEP_FIRST) begin
          // new header abandons any open message
          sum_r   <= SUM_W'(byte_sel);
          rem_r   <= len_r;
          inpkt_r <= 1'b1;
        end else begin
          sum_r <= sum_r + SUM_W'(byte_sel);
          if (!is_hdr) begin
            rem_r <= rem_r - 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_mode;
      dest_r  <= in_dest_uid;
      cls_r   <= in_command_class;
      pid_r   <= in_parameter_id;
      len_r   <= in_data_length;
      dbyte_r <= in_data_byte;
    end
  end

  assign status.in_packet = inpkt_r;
  assign status.step      = step_r;

endmodule

`default_nettype wire

FILE: dv/rdm_packet_framer_unit_tb.sv
`default_nettype none

module rdm_packet_framer_unit_tb;
  import rdm_pf_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  // settling wait after all predicted bytes have come out
  localparam int DRAIN_CYCLES = 32;

  // one input transfer, every field present whatever the mode
  typedef struct {
    logic              mode;
    logic [UID_W-1:0]  dest;
    logic [BYTE_W-1:0] cls;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] dbyte;
  } frame_item_t;

  // one byte on the wire
  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              fin;
  } wire_byte_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_mode;
  logic [UID_W-1:0]     in_dest_uid;
  logic [BYTE_W-1:0]    in_command_class;
  logic [PID_W-1:0]     in_parameter_id;
  logic [BYTE_W-1:0]    in_data_length;
  logic [BYTE_W-1:0]    in_data_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;

  // framer state as predicted
  logic [BYTE_W-1:0] cur_start_code;
  logic [BYTE_W-1:0] cur_sub_start;
  logic [UID_W-1:0]  cur_src_uid;
  logic [MID_W-1:0]  cur_middle;
  logic [SUM_W-1:0]  frame_sum;
  logic [BYTE_W-1:0] bytes_left;
  logic              frame_open;

  wire_byte_t expected_bytes[$];
  int         error_count;
  int         bytes_framed;   // transfers that produced at least one byte
  int         cycle_count;
  bit         bursts_on;
  int         stall_left;

  rdm_packet_framer_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_dest_uid      (in_dest_uid),
    .in_command_class (in_command_class),
    .in_parameter_id  (in_parameter_id),
    .in_data_length   (in_data_length),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rdm_packet_framer_unit regression: fail");
      $finish;
    end
  end

  // receiver back-pressure: random bursts of stalled cycles while bursts_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (bursts_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // every accepted byte is matched against the oldest prediction
  always @(posedge clk) begin
    wire_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: no byte expected, actual %02h (out_last %0b)", out_byte, out_last);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.value) begin
          $error("out_byte: expected %02h, actual %02h", want.value, out_byte);
          error_count++;
        end
        if (out_last !== want.fin) begin
          $error("out_last: expected %0b, actual %0b", want.fin, out_last);
          error_count++;
        end
      end
    end
  end

  // --- prediction ---

  // plain message byte: goes into the checksum
  function automatic void push_byte(input logic [BYTE_W-1:0] b);
    expected_bytes.push_back('{value: b, fin: 1'b0});
    frame_sum = frame_sum + SUM_W'(b);
  endfunction

  // checksum high then low, low byte ends the message
  function automatic void close_frame();
    expected_bytes.push_back('{value: frame_sum[15:8], fin: 1'b0});
    expected_bytes.push_back('{value: frame_sum[7:0], fin: 1'b1});
    frame_open = 1'b0;
    bytes_left = '0;
    frame_sum  = '0;
  endfunction

  // returns the number of bytes this transfer makes
  function automatic int predict_frame(input frame_item_t it);
    int               n_prev;
    logic [BYTE_W-1:0] msg_len;
    n_prev = expected_bytes.size();
    if (it.mode == MODE_HEADER) begin
      frame_sum = '0;
      msg_len = HDR_BYTES + it.len;   // wraps for lengths above 231
      push_byte(cur_start_code);
      push_byte(cur_sub_start);
      push_byte(msg_len);
      for (int i = 5; i >= 0; i--) push_byte(it.dest[8*i +: 8]);
      for (int i = 5; i >= 0; i--) push_byte(cur_src_uid[8*i +: 8]);
      for (int i = 4; i >= 0; i--) push_byte(cur_middle[8*i +: 8]);
      push_byte(it.cls);
      push_byte(it.pid[15:8]);
      push_byte(it.pid[7:0]);
      push_byte(it.len);
      bytes_left = it.len;
      frame_open = 1'b1;
      if (it.len == 0) close_frame();
    end else if (frame_open && bytes_left != 0) begin
      push_byte(it.dbyte);
      bytes_left--;
      if (bytes_left == 0) close_frame();
    end
    return expected_bytes.size() - n_prev;
  endfunction

  function automatic frame_item_t rand_item(input logic mode);
    frame_item_t it;
    it.mode  = mode;
    it.dest  = UID_W'({$urandom, $urandom});
    it.cls   = BYTE_W'($urandom);
    it.pid   = PID_W'($urandom);
    it.len   = BYTE_W'($urandom);
    it.dbyte = BYTE_W'($urandom);
    return it;
  endfunction

  // --- driving ---

  // one input transfer; valid stays up afterwards so back-to-back items keep it high
  task automatic send_item(input frame_item_t it);
    int gap;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= it.mode;
    in_dest_uid      <= it.dest;
    in_command_class <= it.cls;
    in_parameter_id  <= it.pid;
    in_data_length   <= it.len;
    in_data_byte     <= it.dbyte;
    do @(posedge clk); while (in_stall);
    if (predict_frame(it) > 0) bytes_framed++;
  endtask

  task automatic send_header(input logic [BYTE_W-1:0] len);
    frame_item_t it;
    it     = rand_item(MODE_HEADER);
    it.len = len;
    send_item(it);
  endtask

  task automatic send_data(input logic [BYTE_W-1:0] b);
    frame_item_t it;
    it       = rand_item(MODE_DATA);
    it.dbyte = b;
    send_item(it);
  endtask

  // stop sending, let all predicted bytes come out, then let the block settle
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all four registers back to back, block idle
  task automatic write_config(input logic [CFG_DAT_W-1:0] v_start, v_sub, v_src, v_mid);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CFG_DAT_W-1:0] val[4];
    idx = '{CFG_START_CODE, CFG_SUB_START_CODE, CFG_SRC_UID, CFG_MIDDLE_FIELDS};
    val = '{v_start, v_sub, v_src, v_mid};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_START_CODE:     cur_start_code = val[i][BYTE_W-1:0];
        CFG_SUB_START_CODE: cur_sub_start  = val[i][BYTE_W-1:0];
        CFG_SRC_UID:        cur_src_uid    = val[i][UID_W-1:0];
        CFG_MIDDLE_FIELDS:  cur_middle     = val[i][MID_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // random values for all four registers
  task automatic write_config_random();
    write_config(CFG_DAT_W'({$urandom, $urandom}), CFG_DAT_W'({$urandom, $urandom}),
                 CFG_DAT_W'({$urandom, $urandom}), CFG_DAT_W'({$urandom, $urandom}));
  endtask

  // --- tests ---

  // reset register values, empty message
  task automatic test_reset_defaults();
    send_header(8'd0);
    drain_block();
  endtask

  // all-zero and all-one header fields, extreme data bytes
  task automatic test_field_extremes();
    frame_item_t it;
    it = '{mode: MODE_HEADER, dest: '0, cls: '0, pid: '0, len: '0, dbyte: '0};
    send_item(it);
    it = '{mode: MODE_HEADER, dest: '1, cls: '1, pid: '1, len: 8'd2, dbyte: '1};
    send_item(it);
    it = '{mode: MODE_DATA, dest: '1, cls: '1, pid: '1, len: '1, dbyte: '0};
    send_item(it);
    it = '{mode: MODE_DATA, dest: '0, cls: '0, pid: '0, len: '0, dbyte: '1};
    send_item(it);
    drain_block();
  endtask

  // data with no open message is dropped, ahead of and after a message
  task automatic test_stray_data();
    send_data(8'h5a);
    send_header(8'd1);
    send_data(8'ha5);
    send_data(8'h3c);
    drain_block();
  endtask

  // a header cuts off the open message without its checksum
  task automatic test_abandon();
    send_header(8'd3);
    send_data(8'h11);
    send_header(8'd1);
    send_data(8'h22);
    drain_block();
  endtask

  // length byte wraps past 231; message cut short to keep the run brief
  task automatic test_length_wrap();
    send_header(8'd232);
    send_data(8'h80);
    send_header(8'd0);
    drain_block();
  endtask

  // registers at both ends, upper write bits set on the narrow ones
  task automatic test_config_extremes();
    write_config('1, '1, '1, '1);
    send_header(8'd1);
    send_data(8'hff);
    drain_block();
    write_config('0, '0, '0, '0);
    send_header(8'd0);
    drain_block();
  endtask

  // random messages: mostly complete, some cut short, some followed by stray data
  task automatic random_messages(input int target);
    int start;
    int len;
    int n;
    int pick;
    start = bytes_framed;
    while (bytes_framed - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      len = $urandom_range(0, 6);
      else if (pick < 88) len = $urandom_range(7, 40);
      else if (pick < 97) len = $urandom_range(41, 231);
      else                len = $urandom_range(232, 255);
      send_header(BYTE_W'(len));
      n = len;
      if (len > 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, len - 1);
      repeat (n) send_data(BYTE_W'($urandom));
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) send_data(BYTE_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_config_random();
      random_messages(90);
      drain_block();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    bursts_on = 1'b0;
    write_config_random();
    random_messages(40);
    drain_block();
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_mode          = MODE_HEADER;
    in_dest_uid      = '0;
    in_command_class = '0;
    in_parameter_id  = '0;
    in_data_length   = '0;
    in_data_byte     = '0;
    out_stall        = 1'b0;
    error_count      = 0;
    bytes_framed     = 0;
    cycle_count      = 0;
    stall_left       = 0;
    bursts_on        = 1'b1;
    // register and framer values out of reset
    cur_start_code   = 8'hcc;
    cur_sub_start    = 8'h01;
    cur_src_uid      = '0;
    cur_middle       = '0;
    frame_sum        = '0;
    bytes_left       = '0;
    frame_open       = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_stray_data();
    test_abandon();
    test_length_wrap();
    test_config_extremes();
    test_random_traffic();
    test_full_rate();

    if (error_count == 0) begin
      $display("rdm_packet_framer_unit regression: pass");
    end else begin
      $display("rdm_packet_framer_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
